/* hw/rtl/tcbpa_pkg.sv */
// Shared types and constants of the two-class block pool allocator.
package tcbpa_pkg;

    localparam int SMALL_BLOCKS = 2048;
    localparam int LARGE_BLOCKS = 512;

    localparam int HANDLE_W     = 12;
    localparam int SMALL_CNT_W  = 12;
    localparam int LARGE_CNT_W  = 11;
    localparam int LIMIT_W      = 16;
    localparam int SIZE_W       = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;

    localparam int SMALL_AW = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
    localparam int LARGE_AW = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;

    localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RESET = LIMIT_W'(15);
    localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RESET = LIMIT_W'(180);

    localparam logic [HANDLE_W-1:0] NULL_HANDLE  = '0;
    localparam logic [HANDLE_W-1:0] SMALL_LAST   = HANDLE_W'(SMALL_BLOCKS);
    localparam logic [HANDLE_W-1:0] LARGE_LAST   = HANDLE_W'(SMALL_BLOCKS + LARGE_BLOCKS);
    localparam logic [HANDLE_W-1:0] LARGE_BASE_1 = HANDLE_W'(SMALL_BLOCKS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_LIMIT = 2'd0,
        CFG_LARGE_LIMIT = 2'd1
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } state_t;

endpackage

/* hw/rtl/two_class_block_pool_allocator_core.sv */
// Two-class block pool allocator: free lists linked through two link memories.
// Results are registered. An allocation that pops a free list reads the link memory when
// it is accepted and registers its result from the registered read data in ST_POP.
// Throughput: one transaction per cycle while the result channel is not stalled; a pop
// holds off new transactions during ST_POP, since the link memories have a synchronous read port.
// Reset: aresetn (synchronous, active low) empties both lists, clears both counters and
// restores the size limits; link memory contents stay undefined until written.
module two_class_block_pool_allocator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [tcbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcbpa_pkg::LIMIT_W-1:0]    cfg_wr_data,
    // Request channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tcbpa_pkg::OP_W-1:0]       s_op,
    input  logic [tcbpa_pkg::SIZE_W-1:0]     s_req_size,
    input  logic [tcbpa_pkg::HANDLE_W-1:0]   s_free_handle,
    // Result channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcbpa_pkg::HANDLE_W-1:0]   m_alloc_handle,
    output logic [tcbpa_pkg::STATUS_W-1:0]   m_status
);
    import tcbpa_pkg::*;

    // Link memories. Each entry holds the handle below it on its pool's free list.
    logic [HANDLE_W-1:0] small_mem [SMALL_BLOCKS];
    logic [HANDLE_W-1:0] large_mem [LARGE_BLOCKS];

    state_t                  state_reg, state_next;
    logic [LIMIT_W-1:0]      small_limit_reg, large_limit_reg;
    logic [HANDLE_W-1:0]     small_top_reg, small_top_next;
    logic [HANDLE_W-1:0]     large_top_reg, large_top_next;
    logic [SMALL_CNT_W-1:0]  small_cnt_reg, small_cnt_next;
    logic [LARGE_CNT_W-1:0]  large_cnt_reg, large_cnt_next;
    logic                    pop_large_reg, pop_large_next;
    logic [HANDLE_W-1:0]     pop_handle_reg, pop_handle_next;
    logic                    m_valid_reg, m_valid_next;
    logic [HANDLE_W-1:0]     m_handle_reg, m_handle_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    // Memory port controls.
    logic                    small_rd_en, large_rd_en;
    logic                    small_wr_en, large_wr_en;
    logic [SMALL_AW-1:0]     small_addr;
    logic [LARGE_AW-1:0]     large_addr;
    logic [HANDLE_W-1:0]     small_rdata, large_rdata;

    logic                    accept;
    logic                    is_small, is_large_fit;
    logic                    fh_small, fh_large;
    logic [HANDLE_W-1:0]     small_idx_h, large_idx_h;
    logic [SMALL_CNT_W-1:0]  small_cnt_inc;
    logic [LARGE_CNT_W-1:0]  large_cnt_inc;

    // A new transaction is taken only in the idle state, and only when the result
    // register is empty or is being emptied in the same cycle.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_alloc_handle = m_handle_reg;
    assign m_status       = m_status_reg;

    // Pool selection. The small pool wins whenever the size fits its limit, even if
    // the large limit is lower.
    assign is_small     = s_req_size <= {{(SIZE_W-LIMIT_W){1'b0}}, small_limit_reg};
    assign is_large_fit = s_req_size <= {{(SIZE_W-LIMIT_W){1'b0}}, large_limit_reg};

    assign fh_small = (s_free_handle != NULL_HANDLE) && (s_free_handle <= SMALL_LAST);
    assign fh_large = (s_free_handle >= LARGE_BASE_1) && (s_free_handle <= LARGE_LAST);

    assign small_cnt_inc = small_cnt_reg + SMALL_CNT_W'(1);
    assign large_cnt_inc = large_cnt_reg + LARGE_CNT_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (op_t'(s_op) == OP_ALLOC)) begin
                    if (is_small && (small_top_reg != NULL_HANDLE)) begin
                        state_next = ST_POP;
                    end else if (!is_small && is_large_fit && (large_top_reg != NULL_HANDLE)) begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        small_top_next  = small_top_reg;
        large_top_next  = large_top_reg;
        small_cnt_next  = small_cnt_reg;
        large_cnt_next  = large_cnt_reg;
        pop_large_next  = pop_large_reg;
        pop_handle_next = pop_handle_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_handle_next   = m_handle_reg;
        m_status_next   = m_status_reg;
        small_rd_en     = 1'b0;
        large_rd_en     = 1'b0;
        small_wr_en     = 1'b0;
        large_wr_en     = 1'b0;
        small_idx_h     = NULL_HANDLE;
        large_idx_h     = NULL_HANDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = NULL_HANDLE;
                    m_status_next = STAT_IGNORED;
                    unique case (op_t'(s_op))
                        OP_ALLOC: begin
                            if (is_small) begin
                                if (small_top_reg != NULL_HANDLE) begin
                                    // Pop: the result is produced once the link arrives.
                                    m_valid_next    = 1'b0;
                                    small_rd_en     = 1'b1;
                                    small_idx_h     = small_top_reg - HANDLE_W'(1);
                                    pop_large_next  = 1'b0;
                                    pop_handle_next = small_top_reg;
                                end else if (small_cnt_reg < SMALL_CNT_W'(SMALL_BLOCKS)) begin
                                    small_cnt_next = small_cnt_inc;
                                    m_handle_next  = HANDLE_W'(small_cnt_inc);
                                    m_status_next  = STAT_DONE;
                                end else begin
                                    m_status_next = STAT_EXHAUSTED;
                                end
                            end else if (is_large_fit) begin
                                if (large_top_reg != NULL_HANDLE) begin
                                    m_valid_next    = 1'b0;
                                    large_rd_en     = 1'b1;
                                    large_idx_h     = large_top_reg - LARGE_BASE_1;
                                    pop_large_next  = 1'b1;
                                    pop_handle_next = large_top_reg;
                                end else if (large_cnt_reg < LARGE_CNT_W'(LARGE_BLOCKS)) begin
                                    large_cnt_next = large_cnt_inc;
                                    m_handle_next  = HANDLE_W'(SMALL_BLOCKS)
                                                   + HANDLE_W'(large_cnt_inc);
                                    m_status_next  = STAT_DONE;
                                end else begin
                                    m_status_next = STAT_EXHAUSTED;
                                end
                            end else begin
                                m_status_next = STAT_TOO_LARGE;
                            end
                        end
                        OP_FREE: begin
                            // Push: the old top goes into the freed block's link.
                            if (fh_small) begin
                                small_wr_en    = 1'b1;
                                small_idx_h    = s_free_handle - HANDLE_W'(1);
                                small_top_next = s_free_handle;
                                m_status_next  = STAT_DONE;
                            end else if (fh_large) begin
                                large_wr_en    = 1'b1;
                                large_idx_h    = s_free_handle - LARGE_BASE_1;
                                large_top_next = s_free_handle;
                                m_status_next  = STAT_DONE;
                            end
                        end
                        OP_REINIT: begin
                            small_top_next = NULL_HANDLE;
                            large_top_next = NULL_HANDLE;
                            small_cnt_next = '0;
                            large_cnt_next = '0;
                            m_status_next  = STAT_DONE;
                        end
                        OP_UNUSED: begin
                            m_status_next = STAT_IGNORED;
                        end
                        default: begin
                            m_status_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            ST_POP: begin
                // The link read last cycle becomes the new list top.
                if (pop_large_reg) begin
                    large_top_next = large_rdata;
                end else begin
                    small_top_next = small_rdata;
                end
                m_valid_next  = 1'b1;
                m_handle_next = pop_handle_reg;
                m_status_next = STAT_DONE;
            end
            default: begin
            end
        endcase
    end

    assign small_addr = small_idx_h[SMALL_AW-1:0];
    assign large_addr = large_idx_h[LARGE_AW-1:0];

    // Link memories with registered read data. Writes and reads never fall in the
    // same cycle, and a pop always reads in a later cycle than any earlier push.
    always_ff @(posedge aclk) begin
        if (small_wr_en) begin
            small_mem[small_addr] <= small_top_reg;
        end
        if (small_rd_en) begin
            small_rdata <= small_mem[small_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (large_wr_en) begin
            large_mem[large_addr] <= large_top_reg;
        end
        if (large_rd_en) begin
            large_rdata <= large_mem[large_addr];
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            small_limit_reg <= SMALL_LIMIT_RESET;
            large_limit_reg <= LARGE_LIMIT_RESET;
            small_top_reg   <= NULL_HANDLE;
            large_top_reg   <= NULL_HANDLE;
            small_cnt_reg   <= '0;
            large_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            small_top_reg <= small_top_next;
            large_top_reg <= large_top_next;
            small_cnt_reg <= small_cnt_next;
            large_cnt_reg <= large_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                if (cfg_idx_t'(cfg_index) == CFG_SMALL_LIMIT) begin
                    small_limit_reg <= cfg_wr_data;
                end else if (cfg_idx_t'(cfg_index) == CFG_LARGE_LIMIT) begin
                    large_limit_reg <= cfg_wr_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pop_large_reg  <= pop_large_next;
        pop_handle_reg <= pop_handle_next;
        m_handle_reg   <= m_handle_next;
        m_status_reg   <= m_status_next;
    end

endmodule

/* dv/tb_two_class_block_pool_allocator_core.sv */
// Self-checking testbench for the two-class block pool allocator core.
`timescale 1ns / 100ps

module tb_two_class_block_pool_allocator_core;
    import tcbpa_pkg::*;

    // Index used for the one write that no register answers to.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // The allocator state is kept twice. The mirror is advanced when a transaction
    // is accepted and yields the grant that the result must match; the planner is
    // advanced as requests are queued, so that the stimulus knows which handles are
    // live and can free them again.
    localparam int MIRROR  = 0;
    localparam int PLANNER = 1;

    localparam int ITEMS_PER_PHASE = 12;
    localparam int LONG_HOLD       = 300;

    typedef struct packed {
        op_t                 op;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } pool_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        status_t             status;
    } pool_grant_t;

    typedef enum {
        BAND_SMALL,
        BAND_LARGE,
        BAND_OVER
    } size_band_t;

    // Clock, reset and the inputs of the block, all known from time zero.
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LIMIT_W-1:0]   cfg_wr_data   = '0;
    logic                 s_valid       = 1'b0;
    logic [OP_W-1:0]      s_op          = '0;
    logic [SIZE_W-1:0]    s_req_size    = '0;
    logic [HANDLE_W-1:0]  s_free_handle = '0;
    logic                 m_ready       = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [HANDLE_W-1:0]  m_alloc_handle;
    logic [STATUS_W-1:0]  m_status;

    // Size limits as the block holds them; both copies of the state share these,
    // since the registers change only while nothing is in flight.
    logic [LIMIT_W-1:0]   small_limit = SMALL_LIMIT_RESET;
    logic [LIMIT_W-1:0]   large_limit = LARGE_LIMIT_RESET;

    logic [HANDLE_W-1:0]    small_top   [2];
    logic [HANDLE_W-1:0]    large_top   [2];
    logic [SMALL_CNT_W-1:0] small_fresh [2];
    logic [LARGE_CNT_W-1:0] large_fresh [2];
    logic [HANDLE_W-1:0]    small_link  [2][SMALL_BLOCKS];
    logic [HANDLE_W-1:0]    large_link  [2][LARGE_BLOCKS];

    pool_req_t           pending_requests[$];
    pool_grant_t         awaited_grants[$];
    logic [HANDLE_W-1:0] live_handles[$];

    int                  fail_count = 0;

    // Driver and monitor working variables.
    pool_req_t           on_wire;
    int                  gap_left;
    int                  burst_left;
    pool_grant_t         want;
    int                  results_seen;
    int                  hold_left;
    int                  rx_cycle;

    two_class_block_pool_allocator_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_req_size     (s_req_size),
        .s_free_handle  (s_free_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_alloc_handle (m_alloc_handle),
        .m_status       (m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Works out the grant for one request and advances copy m of the state.
    // An allocation first pops its pool's free list and only then takes a block
    // that has never been handed out; a free pushes the handle on its pool's list.
    function automatic pool_grant_t serve_request(int m, pool_req_t r);
        pool_grant_t         g;
        logic                to_small;
        logic [HANDLE_W-1:0] h;
        g.handle = NULL_HANDLE;
        g.status = STAT_IGNORED;
        case (r.op)
            OP_ALLOC: begin
                // The small pool wins whenever the size fits it, even when its
                // limit lies above that of the large pool.
                to_small = (r.size <= SIZE_W'(small_limit));
                if (!to_small && r.size > SIZE_W'(large_limit)) begin
                    g.status = STAT_TOO_LARGE;
                end else begin
                    h = NULL_HANDLE;
                    if (to_small) begin
                        if (small_top[m] >= HANDLE_W'(1) && small_top[m] <= SMALL_LAST) begin
                            h = small_top[m];
                            small_top[m] = small_link[m][h - 1];
                        end else if (small_fresh[m] < SMALL_BLOCKS) begin
                            small_fresh[m] = small_fresh[m] + 1'b1;
                            h = HANDLE_W'(small_fresh[m]);
                        end
                    end else begin
                        if (large_top[m] >= LARGE_BASE_1 && large_top[m] <= LARGE_LAST) begin
                            h = large_top[m];
                            large_top[m] = large_link[m][h - LARGE_BASE_1];
                        end else if (large_fresh[m] < LARGE_BLOCKS) begin
                            large_fresh[m] = large_fresh[m] + 1'b1;
                            h = SMALL_LAST + HANDLE_W'(large_fresh[m]);
                        end
                    end
                    g.handle = h;
                    g.status = (h != NULL_HANDLE) ? STAT_DONE : STAT_EXHAUSTED;
                end
            end
            OP_FREE: begin
                // Double frees are pushed again without any check.
                if (r.handle >= HANDLE_W'(1) && r.handle <= SMALL_LAST) begin
                    small_link[m][r.handle - 1] = small_top[m];
                    small_top[m] = r.handle;
                    g.status = STAT_DONE;
                end else if (r.handle >= LARGE_BASE_1 && r.handle <= LARGE_LAST) begin
                    large_link[m][r.handle - LARGE_BASE_1] = large_top[m];
                    large_top[m] = r.handle;
                    g.status = STAT_DONE;
                end
            end
            OP_REINIT: begin
                // The link memories keep their contents, which are now unreachable.
                small_top[m]   = NULL_HANDLE;
                large_top[m]   = NULL_HANDLE;
                small_fresh[m] = '0;
                large_fresh[m] = '0;
                g.status = STAT_DONE;
            end
            default: begin
                g.status = STAT_IGNORED;
            end
        endcase
        return g;
    endfunction

    // Queues one request and runs it through the planner so that granted handles
    // become candidates for later frees.
    function automatic void queue_request(op_t op, logic [SIZE_W-1:0] size,
                                          logic [HANDLE_W-1:0] handle);
        pool_req_t   r;
        pool_grant_t g;
        r.op     = op;
        r.size   = size;
        r.handle = handle;
        g = serve_request(PLANNER, r);
        if (op == OP_ALLOC && g.status == STAT_DONE) begin
            live_handles.push_back(g.handle);
        end else if (op == OP_REINIT) begin
            live_handles.delete();
        end
        pending_requests.push_back(r);
    endfunction

    // Picks a size in the given band under the present limits, or past both limits when
    // the large band is empty, favouring the limits themselves and the values just past them.
    function automatic logic [SIZE_W-1:0] pick_size(size_band_t band);
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] size;
        top = (small_limit > large_limit) ? SIZE_W'(small_limit) : SIZE_W'(large_limit);
        if (band == BAND_LARGE && large_limit <= small_limit) begin
            band = BAND_OVER;
        end
        case (band)
            BAND_SMALL: begin
                if ($urandom_range(0, 3) == 0) begin
                    size = $urandom_range(0, 1) ? SIZE_W'(small_limit) : '0;
                end else begin
                    size = $urandom_range(0, small_limit);
                end
            end
            BAND_LARGE: begin
                if ($urandom_range(0, 3) == 0) begin
                    size = $urandom_range(0, 1) ? SIZE_W'(large_limit)
                                                : SIZE_W'(small_limit) + 1;
                end else begin
                    size = $urandom_range(small_limit + 1, large_limit);
                end
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: size = top + 1;
                    1: size = '1;
                    default: size = $urandom_range(top + 1, 32'hFFFF_FFFF);
                endcase
            end
        endcase
        return size;
    endfunction

    // One random request. Most of them allocate or give back a live handle, so the
    // free lists grow and are popped; the rest are stray frees, double frees,
    // re-inits and the unused op code.
    function automatic void queue_random_request();
        int                  sel;
        int                  pick;
        int                  idx;
        size_band_t          band;
        logic [HANDLE_W-1:0] h;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            pick = $urandom_range(0, 9);
            band = (pick < 5) ? BAND_SMALL : (pick < 9) ? BAND_LARGE : BAND_OVER;
            queue_request(OP_ALLOC, pick_size(band), HANDLE_W'($urandom));
        end else if (sel < 75 && live_handles.size() != 0) begin
            idx = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[idx];
            live_handles.delete(idx);
            queue_request(OP_FREE, $urandom, h);
        end else if (sel < 80 && live_handles.size() != 0) begin
            // The handle stays on the live list, so it is likely to be freed twice.
            idx = $urandom_range(0, live_handles.size() - 1);
            queue_request(OP_FREE, $urandom, live_handles[idx]);
        end else if (sel < 87) begin
            case ($urandom_range(0, 3))
                0: h = NULL_HANDLE;
                1: h = HANDLE_W'($urandom_range(LARGE_LAST + 1, 4095));
                2: h = HANDLE_W'($urandom);
                default: h = HANDLE_W'($urandom_range(1, LARGE_LAST));
            endcase
            queue_request(OP_FREE, $urandom, h);
        end else if (sel < 92) begin
            queue_request(OP_UNUSED, $urandom, HANDLE_W'($urandom));
        end else if (sel < 94) begin
            queue_request(OP_REINIT, $urandom, HANDLE_W'($urandom));
        end else begin
            queue_request(OP_ALLOC, $urandom, HANDLE_W'($urandom));
        end
    endfunction

    // Waits, sampling on the falling edge, until every queued transaction has been
    // accepted and every awaited result has come back.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || awaited_grants.size() != 0);
    endtask

    // Writes one register through the plain write port; only called while idle.
    task automatic set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_SMALL_LIMIT) begin
            small_limit = value;
        end else if (idx == CFG_LARGE_LIMIT) begin
            large_limit = value;
        end
    endtask

    // Sender: works in bursts with random gaps between them. A transaction that has
    // been offered is held, payload and all, until the block accepts it, and the
    // accepted transaction is run through the mirror at that same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = $urandom_range(1, 24);
        end else begin
            if (s_valid && s_ready) begin
                awaited_grants.push_back(serve_request(MIRROR, on_wire));
            end
            if (s_valid && !s_ready) begin
                // Stalled: the offer stands unchanged.
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                on_wire = pending_requests.pop_front();
                s_op          <= on_wire.op;
                s_req_size    <= on_wire.size;
                s_free_handle <= on_wire.handle;
                s_valid       <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    // A quarter of the bursts run straight into the next one.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 24);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result against the oldest awaited grant and stalls on a
    // pattern picked from rx_cycle. Twice in the run it holds off for a long stretch
    // while the sender keeps offering, so the block backs up and drops s_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            results_seen = 0;
            hold_left    = 0;
            rx_cycle     = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (awaited_grants.size() == 0) begin
                    $error("result with no transaction outstanding: alloc_handle %0d status %0d",
                           m_alloc_handle, m_status);
                    fail_count = fail_count + 1;
                end else begin
                    want = awaited_grants.pop_front();
                    if (m_alloc_handle !== want.handle) begin
                        $error("alloc_handle: expected %0d, got %0d", want.handle, m_alloc_handle);
                        fail_count = fail_count + 1;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count = fail_count + 1;
                    end
                end
                if (results_seen == 60 || results_seen == 400) begin
                    hold_left = LONG_HOLD;
                end
            end
            rx_cycle = rx_cycle + 1;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case ((rx_cycle >> 8) % 8)
                    2: m_ready <= ($urandom_range(0, 1) == 0);
                    3: m_ready <= (rx_cycle % 4 == 0);
                    4: m_ready <= ($urandom_range(0, 7) != 0);
                    5: m_ready <= ($urandom_range(0, 7) == 0);
                    6: m_ready <= ((rx_cycle >> 3) % 2 == 0);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: a directed opening under the reset limits, a random phase under each
    // of several limit settings, and a run that drains the large pool to exhaustion.
    initial begin
        for (int m = 0; m < 2; m++) begin
            small_top[m]   = NULL_HANDLE;
            large_top[m]   = NULL_HANDLE;
            small_fresh[m] = '0;
            large_fresh[m] = '0;
            for (int i = 0; i < SMALL_BLOCKS; i++) small_link[m][i] = '0;
            for (int i = 0; i < LARGE_BLOCKS; i++) large_link[m][i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Both limits and the sizes just past them, the widest size, pops from both
        // lists, frees of null and out-of-range handles, the last block of each
        // pool, a double free that makes the list hand out one block twice, the
        // unused op code, and fresh blocks again after a re-init.
        queue_request(OP_ALLOC, 0, '0);
        queue_request(OP_ALLOC, 15, '0);
        queue_request(OP_ALLOC, 16, '0);
        queue_request(OP_ALLOC, 180, '0);
        queue_request(OP_ALLOC, 181, '0);
        queue_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
        queue_request(OP_FREE, '0, HANDLE_W'(2));
        queue_request(OP_FREE, '0, LARGE_BASE_1 + HANDLE_W'(1));
        queue_request(OP_ALLOC, 1, '0);
        queue_request(OP_ALLOC, 100, '0);
        queue_request(OP_ALLOC, 5, '0);
        queue_request(OP_FREE, '0, NULL_HANDLE);
        queue_request(OP_FREE, '0, LARGE_LAST + HANDLE_W'(1));
        queue_request(OP_FREE, '0, '1);
        queue_request(OP_FREE, '0, SMALL_LAST);
        queue_request(OP_FREE, '0, LARGE_LAST);
        queue_request(OP_ALLOC, 180, '0);
        queue_request(OP_FREE, '0, HANDLE_W'(1));
        queue_request(OP_FREE, '0, HANDLE_W'(1));
        queue_request(OP_ALLOC, 7, '0);
        queue_request(OP_ALLOC, 7, '0);
        queue_request(OP_UNUSED, 32'hFFFF_FFFF, '1);
        queue_request(OP_FREE, '0, HANDLE_W'(3));
        queue_request(OP_ALLOC, 0, '0);
        queue_request(OP_REINIT, '0, '0);
        queue_request(OP_ALLOC, 0, '0);
        queue_request(OP_ALLOC, 16, '0);
        wait_quiet();

        // Random phases: both limits at zero, both at full scale, a small limit above
        // the large one, the reverse, the reset values, and a random pair.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    set_limit(CFG_SMALL_LIMIT, '0);
                    set_limit(CFG_LARGE_LIMIT, '0);
                end
                1: begin
                    set_limit(CFG_SMALL_LIMIT, '1);
                    set_limit(CFG_LARGE_LIMIT, '1);
                end
                2: begin
                    set_limit(CFG_SMALL_LIMIT, '1);
                    set_limit(CFG_LARGE_LIMIT, '0);
                end
                3: begin
                    set_limit(CFG_SMALL_LIMIT, '0);
                    set_limit(CFG_LARGE_LIMIT, '1);
                end
                4: begin
                    set_limit(CFG_SMALL_LIMIT, SMALL_LIMIT_RESET);
                    set_limit(CFG_LARGE_LIMIT, LARGE_LIMIT_RESET);
                end
                default: begin
                    set_limit(CFG_SMALL_LIMIT, LIMIT_W'($urandom_range(0, 300)));
                    set_limit(CFG_LARGE_LIMIT, LIMIT_W'($urandom_range(0, 65535)));
                end
            endcase
            @(negedge aclk);
            repeat (ITEMS_PER_PHASE) queue_random_request();
            wait_quiet();
        end

        // Drain: a write to an index that no register answers must leave the limits
        // alone. Then every block of the large pool is handed out and one more asked
        // for, after which one block is returned and asked for twice.
        set_limit(CFG_SMALL_LIMIT, 16'd100);
        set_limit(CFG_LARGE_LIMIT, 16'd5000);
        set_limit(CFG_SPARE, 16'hA5A5);
        @(negedge aclk);
        queue_request(OP_REINIT, '0, '0);
        repeat (LARGE_BLOCKS + 1) queue_request(OP_ALLOC, pick_size(BAND_LARGE),
                                                HANDLE_W'($urandom));
        queue_request(OP_FREE, $urandom, live_handles[0]);
        repeat (2) queue_request(OP_ALLOC, pick_size(BAND_LARGE), '0);
        wait_quiet();

        // Wait before the verdict so that any stray result can still show up.
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: ends the run with FAIL should the stimulus not finish in time.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tcbpa_pkg.sv
hw/rtl/two_class_block_pool_allocator_core.sv
dv/tb_two_class_block_pool_allocator_core.sv
